[rtl/uvs_pkg.sv]
package uvs_pkg;

   localparam int IDX_W        = 10;
   localparam int CFG_W        = 16;
   localparam int CORNER_W     = 20;
   localparam int POS_W        = 17;
   localparam int CORDIC_STEPS = 20;
   localparam int XW           = 27;   // CORDIC x/y, 24 fractional bits
   localparam int ZW           = 32;   // residual angle, 2^-32 turn
   localparam int TW           = 20;   // trig values, 16 fractional bits
   localparam int PW           = 40;   // product width

   localparam logic signed [XW-1:0] CORDIC_GAIN = XW'(10188014);

   localparam logic [1:0] REG_LON    = 2'd0;
   localparam logic [1:0] REG_LAT    = 2'd1;
   localparam logic [1:0] REG_RADIUS = 2'd2;

   localparam logic [1:0] ST_VERTEX = 2'd0;
   localparam logic [1:0] ST_TRI    = 2'd1;
   localparam logic [1:0] ST_ERROR  = 2'd2;

   typedef struct packed {
      logic             kind;
      logic [IDX_W-1:0] lat;
      logic [IDX_W-1:0] lon;
      logic             err;
   } tag_type;

   typedef struct packed {
      logic                last;
      logic [CORNER_W-1:0] c3;
      logic [CORNER_W-1:0] c2;
      logic [CORNER_W-1:0] c1;
      logic [POS_W-1:0]    pz;
      logic [POS_W-1:0]    py;
      logic [POS_W-1:0]    px;
      logic [1:0]          status;
   } result_type;

   function automatic logic [ZW-1:0] atan_turn(input int unsigned step);
      logic [ZW-1:0] v;
      case (step)
         0:       v = 32'd536870912;
         1:       v = 32'd316933406;
         2:       v = 32'd167458907;
         3:       v = 32'd85004756;
         4:       v = 32'd42667331;
         5:       v = 32'd21354465;
         6:       v = 32'd10679838;
         7:       v = 32'd5340245;
         8:       v = 32'd2670163;
         9:       v = 32'd1335087;
         10:      v = 32'd667544;
         11:      v = 32'd333772;
         12:      v = 32'd166886;
         13:      v = 32'd83443;
         14:      v = 32'd41722;
         15:      v = 32'd20861;
         16:      v = 32'd10430;
         17:      v = 32'd5215;
         18:      v = 32'd2608;
         19:      v = 32'd1304;
         default: v = '0;
      endcase
      return v;
   endfunction

   // round Q.16 product back by 16 bits, clamp to +-65535
   function automatic logic [POS_W-1:0] round_sat(input logic signed [PW-1:0] v);
      logic signed [PW-1:0] t;
      t = (v + 40'sd32768) >>> 16;
      if (t > 40'sd65535) return 17'sd65535;
      else if (t < -40'sd65535) return -17'sd65535;
      else return t[POS_W-1:0];
   endfunction

endpackage

[rtl/uvs_div_cell.sv]
module uvs_div_cell #(
   parameter int DW = 11,
   parameter int QW = 17
) (
   input  logic          clock,
   input  logic          en,
   input  logic [DW-1:0] den,
   input  logic [DW-1:0] src_r,
   input  logic [QW-1:0] src_n,
   input  logic [QW-1:0] src_q,
   output logic [DW-1:0] dst_r,
   output logic [QW-1:0] dst_n,
   output logic [QW-1:0] dst_q
);
   logic [DW-1:0] r_ff, r_in;
   logic [QW-1:0] n_ff, q_ff;
   logic [DW:0]   trial;
   logic          take;

   // one restoring quotient bit per cell
   always_comb begin
      trial = {src_r, src_n[QW-1]};
      take  = (trial >= {1'b0, den});
      r_in  = take ? DW'(trial - {1'b0, den}) : trial[DW-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff <= r_in;
         n_ff <= {src_n[QW-2:0], 1'b0};
         q_ff <= {src_q[QW-2:0], take};
      end
   end

   assign dst_r = r_ff;
   assign dst_n = n_ff;
   assign dst_q = q_ff;
endmodule

[rtl/uvs_cordic_cell.sv]
module uvs_cordic_cell #(
   parameter int STEP = 0
) (
   input  logic clock,
   input  logic en,
   input  logic signed [uvs_pkg::XW-1:0] src_x,
   input  logic signed [uvs_pkg::XW-1:0] src_y,
   input  logic signed [uvs_pkg::ZW-1:0] src_z,
   input  logic                          src_neg,
   output logic signed [uvs_pkg::XW-1:0] dst_x,
   output logic signed [uvs_pkg::XW-1:0] dst_y,
   output logic signed [uvs_pkg::ZW-1:0] dst_z,
   output logic                          dst_neg
);
   import uvs_pkg::*;

   localparam logic signed [ZW-1:0] ATAN = atan_turn(STEP);

   logic signed [XW-1:0] x_ff, y_ff, x_in, y_in, sx, sy;
   logic signed [ZW-1:0] z_ff, z_in;
   logic                 neg_ff;

   always_comb begin
      sx = src_x >>> STEP;
      sy = src_y >>> STEP;
      if (!src_z[ZW-1]) begin
         x_in = src_x - sy;
         y_in = src_y + sx;
         z_in = src_z - ATAN;
      end else begin
         x_in = src_x + sy;
         y_in = src_y - sx;
         z_in = src_z + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         z_ff   <= z_in;
         neg_ff <= src_neg;
      end
   end

   assign dst_x   = x_ff;
   assign dst_y   = y_ff;
   assign dst_z   = z_ff;
   assign dst_neg = neg_ff;
endmodule

[rtl/uv_sphere_tessellator.sv]
// UV-sphere tessellator.
// req channel: one item per transfer; tuser = kind (0 vertex, 1 quad), tdata holds
// the grid point. rsp channel: tuser = status, tlast marks the last result of an
// item, tdata holds the vertex position and triangle corners.
// csr channel: write longitude_segments (0), latitude_segments (1),
// sphere_radius (2); always ready, write only while the block is idle.
// Pipeline: the input register loads at the transfer edge, then ANGLE_BITS+1
// divider cells, angle fold, 20 CORDIC cells, two multiplier stages and the
// output register.
// Throughput: one item per cycle; a quad that yields two triangles holds the
// pipeline while the second triangle goes out.
// All stages advance together; when rsp is stalled the whole pipeline and
// req_tready stall with it, nothing is dropped.
// Reset empties the pipeline and loads the register defaults (64, 32, 100.0).
module uv_sphere_tessellator #(
   parameter int MAX_SEGMENTS = 1024,
   parameter int ANGLE_BITS   = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [23:0]  req_tdata,   // lat_index[9:0], lon_index[19:10], zero pad
   input  logic [0:0]   req_tuser,   // kind
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [111:0] rsp_tdata,   // pos_x, pos_y, pos_z, corner_first,
                                     // corner_second, corner_third, zero pad
   output logic [1:0]   rsp_tuser,   // status
   output logic         rsp_tlast,   // last_result
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_addr,
   input  logic [15:0]  csr_wdata
);
   import uvs_pkg::*;

   localparam int SW = $clog2(MAX_SEGMENTS);
   localparam int DW = SW + 1;
   localparam int QW = ANGLE_BITS + 1;
   localparam int NW = IDX_W + ANGLE_BITS + 1;
   localparam int TD = QW + 24;
   localparam int M1 = QW + 22;

   logic [IDX_W-1:0] lon_seg_ff, lat_seg_ff;
   logic [CFG_W-1:0] radius_ff;
   logic [SW-1:0]    l_eff, s_eff;
   logic             adv;

   // configuration
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         lon_seg_ff <= IDX_W'(64);
         lat_seg_ff <= IDX_W'(32);
         radius_ff  <= CFG_W'(25600);
      end else if (csr_valid) begin
         case (csr_addr)
            REG_LON:    lon_seg_ff <= csr_wdata[IDX_W-1:0];
            REG_LAT:    lat_seg_ff <= csr_wdata[IDX_W-1:0];
            REG_RADIUS: radius_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (lon_seg_ff < IDX_W'(3)) l_eff = SW'(3);
      else if (32'(lon_seg_ff) > MAX_SEGMENTS - 1) l_eff = SW'(MAX_SEGMENTS - 1);
      else l_eff = SW'(lon_seg_ff);
      if (lat_seg_ff < IDX_W'(2)) s_eff = SW'(2);
      else if (32'(lat_seg_ff) > MAX_SEGMENTS - 1) s_eff = SW'(MAX_SEGMENTS - 1);
      else s_eff = SW'(lat_seg_ff);
   end

   // item tags travel beside the datapath
   tag_type tag_ff [TD];
   logic    vld_ff [TD];
   tag_type tag_in;

   always_comb begin
      tag_in.kind = req_tuser[0];
      tag_in.lat  = req_tdata[IDX_W-1:0];
      tag_in.lon  = req_tdata[2*IDX_W-1:IDX_W];
      if (req_tuser[0])
         tag_in.err = (32'(tag_in.lat) >= 32'(s_eff)) || (32'(tag_in.lon) >= 32'(l_eff));
      else
         tag_in.err = (32'(tag_in.lat) > 32'(s_eff)) || (32'(tag_in.lon) > 32'(l_eff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TD; i++) vld_ff[i] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_tvalid;
         for (int i = 1; i < TD; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tag_ff[0] <= tag_in;
         for (int i = 1; i < TD; i++) tag_ff[i] <= tag_ff[i-1];
      end
   end

   // angle dividers: theta = (lat*2^AB + S) / 2S, phi = (lon*2^AB + L/2) / L
   logic [DW-1:0] den_t, den_p;
   logic [NW-1:0] num_t, num_p;
   logic [DW-1:0] rt [QW+1];
   logic [DW-1:0] rp [QW+1];
   logic [QW-1:0] nt [QW+1];
   logic [QW-1:0] np [QW+1];
   logic [QW-1:0] qt [QW+1];
   logic [QW-1:0] qp [QW+1];

   assign den_t = {s_eff, 1'b0};
   assign den_p = DW'(l_eff);
   assign num_t = (NW'(tag_ff[0].lat) << ANGLE_BITS) + NW'(den_t >> 1);
   assign num_p = (NW'(tag_ff[0].lon) << ANGLE_BITS) + NW'(den_p >> 1);
   assign rt[0] = DW'(num_t >> QW);
   assign rp[0] = DW'(num_p >> QW);
   assign nt[0] = num_t[QW-1:0];
   assign np[0] = num_p[QW-1:0];
   assign qt[0] = '0;
   assign qp[0] = '0;

   for (genvar k = 0; k < QW; k++) begin : g_div
      uvs_div_cell #(.DW(DW), .QW(QW)) u_div_t (
         .clock(clock), .en(adv), .den(den_t),
         .src_r(rt[k]), .src_n(nt[k]), .src_q(qt[k]),
         .dst_r(rt[k+1]), .dst_n(nt[k+1]), .dst_q(qt[k+1]));
      uvs_div_cell #(.DW(DW), .QW(QW)) u_div_p (
         .clock(clock), .en(adv), .den(den_p),
         .src_r(rp[k]), .src_n(np[k]), .src_q(qp[k]),
         .dst_r(rp[k+1]), .dst_n(np[k+1]), .dst_q(qp[k+1]));
   end

   // fold [1/4, 3/4) turn into the CORDIC range by a half turn
   logic [ZW-1:0] ang_t, ang_p, sum_t, sum_p;
   logic signed [ZW-1:0] zt_ff, zp_ff;
   logic nt_ff, np_ff;

   always_comb begin
      ang_t = ZW'(qt[QW][ANGLE_BITS-1:0]) << (ZW - ANGLE_BITS);
      ang_p = ZW'(qp[QW][ANGLE_BITS-1:0]) << (ZW - ANGLE_BITS);
      sum_t = ang_t + 32'h4000_0000;
      sum_p = ang_p + 32'h4000_0000;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         zt_ff <= sum_t[ZW-1] ? (ang_t ^ 32'h8000_0000) : ang_t;
         zp_ff <= sum_p[ZW-1] ? (ang_p ^ 32'h8000_0000) : ang_p;
         nt_ff <= sum_t[ZW-1];
         np_ff <= sum_p[ZW-1];
      end
   end

   logic signed [XW-1:0] cxt [CORDIC_STEPS+1];
   logic signed [XW-1:0] cyt [CORDIC_STEPS+1];
   logic signed [ZW-1:0] czt [CORDIC_STEPS+1];
   logic                 cnt [CORDIC_STEPS+1];
   logic signed [XW-1:0] cxp [CORDIC_STEPS+1];
   logic signed [XW-1:0] cyp [CORDIC_STEPS+1];
   logic signed [ZW-1:0] czp [CORDIC_STEPS+1];
   logic                 cnp [CORDIC_STEPS+1];

   assign cxt[0] = CORDIC_GAIN;
   assign cyt[0] = '0;
   assign czt[0] = zt_ff;
   assign cnt[0] = nt_ff;
   assign cxp[0] = CORDIC_GAIN;
   assign cyp[0] = '0;
   assign czp[0] = zp_ff;
   assign cnp[0] = np_ff;

   for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_cordic
      uvs_cordic_cell #(.STEP(j)) u_cor_t (
         .clock(clock), .en(adv),
         .src_x(cxt[j]), .src_y(cyt[j]), .src_z(czt[j]), .src_neg(cnt[j]),
         .dst_x(cxt[j+1]), .dst_y(cyt[j+1]), .dst_z(czt[j+1]), .dst_neg(cnt[j+1]));
      uvs_cordic_cell #(.STEP(j)) u_cor_p (
         .clock(clock), .en(adv),
         .src_x(cxp[j]), .src_y(cyp[j]), .src_z(czp[j]), .src_neg(cnp[j]),
         .dst_x(cxp[j+1]), .dst_y(cyp[j+1]), .dst_z(czp[j+1]), .dst_neg(cnp[j+1]));
   end

   // round to 16 fractional bits, undo the fold
   logic signed [XW-1:0] rxt, ryt, rxp, ryp;
   logic signed [TW-1:0] ct, st, cp, sp;
   logic signed [PW-1:0] prod_x, prod_z, prod_y;
   logic signed [CFG_W:0] rad_s;

   assign rad_s = $signed({1'b0, radius_ff});

   always_comb begin
      rxt = cxt[CORDIC_STEPS] + XW'(128);
      ryt = cyt[CORDIC_STEPS] + XW'(128);
      rxp = cxp[CORDIC_STEPS] + XW'(128);
      ryp = cyp[CORDIC_STEPS] + XW'(128);
      ct  = TW'(rxt >>> 8);
      st  = TW'(ryt >>> 8);
      cp  = TW'(rxp >>> 8);
      sp  = TW'(ryp >>> 8);
      if (cnt[CORDIC_STEPS]) begin
         ct = -ct;
         st = -st;
      end
      if (cnp[CORDIC_STEPS]) begin
         cp = -cp;
         sp = -sp;
      end
      prod_x = st * cp;
      prod_z = st * sp;
      prod_y = rad_s * ct;
   end

   logic signed [PW-1:0] px1_t, pz1_t;
   logic signed [TW-1:0] px1_ff, pz1_ff;
   logic [POS_W-1:0]     py1_ff;

   assign px1_t = (prod_x + 40'sd32768) >>> 16;
   assign pz1_t = (prod_z + 40'sd32768) >>> 16;

   always_ff @(posedge clock) begin
      if (adv) begin
         px1_ff <= px1_t[TW-1:0];
         pz1_ff <= pz1_t[TW-1:0];
         py1_ff <= round_sat(prod_y);
      end
   end

   // second multiplier stage; quad corner indices alongside
   logic signed [PW-1:0] prod_x2, prod_z2;
   logic [POS_W-1:0]     px2_ff, py2_ff, pz2_ff;
   logic [CORNER_W-1:0]  a_ff, c_ff, a_in;
   logic [31:0]          a_full;
   logic [SW:0]          row;

   assign prod_x2 = rad_s * px1_ff;
   assign prod_z2 = rad_s * pz1_ff;
   assign row     = (SW+1)'(l_eff) + 1'b1;
   assign a_full  = 32'(tag_ff[M1].lat) * 32'(row) + 32'(tag_ff[M1].lon);
   assign a_in    = a_full[CORNER_W-1:0];

   always_ff @(posedge clock) begin
      if (adv) begin
         px2_ff <= round_sat(prod_x2);
         pz2_ff <= round_sat(prod_z2);
         py2_ff <= py1_ff;
         a_ff   <= a_in;
         c_ff   <= a_in + CORNER_W'(row);
      end
   end

   // result assembly and output register
   tag_type    tg;
   result_type first, second;
   logic       two, upper, lower;

   always_comb begin
      tg     = tag_ff[TD-1];
      first  = '0;
      second = '0;
      upper  = (tg.lat != '0);
      lower  = ((IDX_W+2)'(tg.lat) + 1'b1) != (IDX_W+2)'(s_eff);
      two    = 1'b0;
      if (tg.err) begin
         first.status = ST_ERROR;
         first.last   = 1'b1;
      end else if (!tg.kind) begin
         first.status = ST_VERTEX;
         first.px     = px2_ff;
         first.py     = py2_ff;
         first.pz     = pz2_ff;
         first.last   = 1'b1;
      end else begin
         first.status  = ST_TRI;
         second.status = ST_TRI;
         second.c1     = a_ff + 1'b1;
         second.c2     = c_ff;
         second.c3     = c_ff + 1'b1;
         second.last   = 1'b1;
         if (upper) begin
            first.c1  = a_ff;
            first.c2  = c_ff;
            first.c3  = a_ff + 1'b1;
            first.last = !lower;
            two       = lower;
         end else begin
            first = second;
         end
      end
   end

   logic       rsp_valid_ff, pend_ff;
   result_type rsp_data_ff, pend_data_ff;

   assign adv = !rsp_valid_ff || (rsp_tready && !pend_ff);
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= vld_ff[TD-1];
         pend_ff      <= vld_ff[TD-1] && two;
      end else if (rsp_tready && pend_ff) begin
         pend_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff  <= first;
         pend_data_ff <= second;
      end else if (rsp_tready && pend_ff) begin
         rsp_data_ff <= pend_data_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_data_ff.status;
   assign rsp_tlast  = rsp_data_ff.last;
   assign rsp_tdata  = {1'b0, rsp_data_ff.c3, rsp_data_ff.c2, rsp_data_ff.c1,
                        rsp_data_ff.pz, rsp_data_ff.py, rsp_data_ff.px};

   // a held second triangle only sits behind a visible, non-final first one
   a_pend_valid: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> rsp_valid_ff && !rsp_data_ff.last && rsp_data_ff.status == ST_TRI)
      else $error("pending triangle without a leading triangle");

   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.status == ST_ERROR |-> rsp_data_ff.last)
      else $error("error result not marked last");

   a_vtx_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.status == ST_VERTEX |-> rsp_data_ff.last)
      else $error("vertex result not marked last");

   a_second_last: assert property (@(posedge clock) disable iff (reset)
      pend_ff && rsp_tready |=> rsp_valid_ff && rsp_data_ff.last && !pend_ff)
      else $error("second triangle lost or not final");
endmodule

[tb/testbench.sv]
module testbench;
   import uvs_pkg::*;

   typedef struct {
      bit       kind;
      bit [9:0] lat;
      bit [9:0] lon;
   } grid_req_type;

   typedef struct {
      logic [1:0]          status;
      logic [POS_W-1:0]    px, py, pz;
      logic [CORNER_W-1:0] c1, c2, c3;
      logic                last;
   } mesh_out_type;

   localparam int FLUSH_CYCLES = 60;
   localparam int CYCLE_LIMIT  = 400000;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [23:0]  req_tdata = '0;
   logic [0:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [111:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         rsp_tlast;
   logic         csr_valid = 0;
   logic         csr_ready;
   logic [1:0]   csr_addr = '0;
   logic [15:0]  csr_wdata = '0;

   uv_sphere_tessellator dut (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   grid_req_type pending_reqs[$];
   mesh_out_type expected_mesh[$];
   int unsigned lon_segs_reg, lat_segs_reg, radius_reg;
   int  mismatches = 0;
   int  tx_idle = 0, rx_idle = 0;
   bit  calm = 0;
   longint cycles = 0;

   const longint atan_lut[20] = '{536870912, 316933406, 167458907, 85004756, 42667331,
      21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304};

   function automatic int unsigned clamp_segs(int unsigned v, int unsigned lo);
      if (v < lo) return lo;
      if (v > 1023) return 1023;
      return v;
   endfunction

   function automatic logic [31:0] angle_turn(longint unsigned num, longint unsigned den);
      longint unsigned a;
      a = ((num << 16) + den / 2) / den;
      return {a[15:0], 16'h0};
   endfunction

   // rotation to cos/sin in Q.16, folding the left half plane first
   function automatic void sincos(input logic [31:0] ang, output longint c, output longint s);
      logic [31:0] probe;
      bit flip;
      longint x, y, z, nx;
      probe = ang + 32'h4000_0000;
      flip = probe[31];
      if (flip) ang = ang - 32'h8000_0000;
      z = longint'($signed(ang));
      x = 10188014;
      y = 0;
      for (int i = 0; i < 20; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z = z - atan_lut[i];
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z = z + atan_lut[i];
         end
         x = nx;
      end
      x = (x + 128) >>> 8;
      y = (y + 128) >>> 8;
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic logic [POS_W-1:0] scale_pos(longint r, longint f);
      longint v;
      v = (r * f + 32768) >>> 16;
      if (v > 65535) v = 65535;
      if (v < -65535) v = -65535;
      return v[POS_W-1:0];
   endfunction

   function automatic void tessellate(grid_req_type q);
      int unsigned lsegs, ssegs, row, a, b, c, d;
      longint ct, st, cp, sp, r;
      mesh_out_type m;
      lsegs = clamp_segs(lon_segs_reg, 3);
      ssegs = clamp_segs(lat_segs_reg, 2);
      r = radius_reg;
      m = '{status: ST_ERROR, px: 0, py: 0, pz: 0, c1: 0, c2: 0, c3: 0, last: 1};
      if (!q.kind) begin
         if (q.lat > ssegs || q.lon > lsegs) begin
            expected_mesh.insert(expected_mesh.size(), m);
            return;
         end
         sincos(angle_turn(q.lat, 2 * ssegs), ct, st);
         sincos(angle_turn(q.lon, lsegs), cp, sp);
         m.status = ST_VERTEX;
         m.px = scale_pos(r, (st * cp + 32768) >>> 16);
         m.py = scale_pos(r, ct);
         m.pz = scale_pos(r, (st * sp + 32768) >>> 16);
         expected_mesh.insert(expected_mesh.size(), m);
         return;
      end
      if (q.lat >= ssegs || q.lon >= lsegs) begin
         expected_mesh.insert(expected_mesh.size(), m);
         return;
      end
      row = lsegs + 1;
      a = q.lat * row + q.lon;
      b = a + 1;
      c = (q.lat + 1) * row + q.lon;
      d = c + 1;
      m.status = ST_TRI;
      if (q.lat != 0) begin
         m.c1 = a[19:0]; m.c2 = c[19:0]; m.c3 = b[19:0];
         m.last = (q.lat == ssegs - 1);
         expected_mesh.insert(expected_mesh.size(), m);
      end
      if (q.lat != ssegs - 1) begin
         m.c1 = b[19:0]; m.c2 = c[19:0]; m.c3 = d[19:0];
         m.last = 1;
         expected_mesh.insert(expected_mesh.size(), m);
      end
   endfunction

   // request driver
   always @(posedge clock) begin
      grid_req_type q;
      if (reset) begin
         req_tvalid <= 0;
      end else begin
         if (req_tvalid && req_tready)
            tessellate('{kind: req_tuser[0], lat: req_tdata[9:0], lon: req_tdata[19:10]});
         if (!req_tvalid || req_tready) begin
            if (tx_idle > 0) begin
               tx_idle <= tx_idle - 1;
               req_tvalid <= 0;
            end else if (!calm && $urandom_range(0, 19) == 0) begin
               tx_idle <= $urandom_range(0, 14);
               req_tvalid <= 0;
            end else if (pending_reqs.size() > 0) begin
               q = pending_reqs.pop_front();
               req_tvalid <= 1;
               req_tuser <= q.kind;
               req_tdata <= {4'b0, q.lon, q.lat};
            end else begin
               req_tvalid <= 0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      mesh_out_type got, want;
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = '{status: rsp_tuser, px: rsp_tdata[16:0], py: rsp_tdata[33:17],
                    pz: rsp_tdata[50:34], c1: rsp_tdata[70:51], c2: rsp_tdata[90:71],
                    c3: rsp_tdata[110:91], last: rsp_tlast};
            if (expected_mesh.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
               want = expected_mesh.pop_front();
               if (got.status !== want.status || got.px !== want.px || got.py !== want.py ||
                   got.pz !== want.pz || got.c1 !== want.c1 || got.c2 !== want.c2 ||
                   got.c3 !== want.c3 || got.last !== want.last) begin
                  mismatches++;
                  if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
               end
            end
         end
         if (rx_idle > 0) begin
            rx_idle <= rx_idle - 1;
            rsp_tready <= 0;
         end else if (!calm && $urandom_range(0, 19) == 0) begin
            rx_idle <= $urandom_range(0, 14);
            rsp_tready <= 0;
         end else begin
            rsp_tready <= 1;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic csr_write(logic [1:0] addr, int unsigned value);
      @(posedge clock);
      csr_valid <= 1;
      csr_addr <= addr;
      csr_wdata <= value[15:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      case (addr)
         REG_LON:    lon_segs_reg = value & 16'h3FF;
         REG_LAT:    lat_segs_reg = value & 16'h3FF;
         REG_RADIUS: radius_reg = value & 16'hFFFF;
         default: ;
      endcase
   endtask

   task automatic set_shape(int unsigned lon, int unsigned lat, int unsigned rad);
      csr_write(REG_LON, lon);
      csr_write(REG_LAT, lat);
      csr_write(REG_RADIUS, rad);
   endtask

   task automatic push_req(bit kind, int unsigned lat, int unsigned lon);
      grid_req_type q;
      q = '{kind: kind, lat: lat[9:0], lon: lon[9:0]};
      pending_reqs.insert(pending_reqs.size(), q);
   endtask

   // mostly in-range grid points, edges and just past them; some full-range noise
   task automatic push_random(int n);
      int unsigned ls, ss;
      ls = clamp_segs(lon_segs_reg, 3);
      ss = clamp_segs(lat_segs_reg, 2);
      repeat (n) begin
         if ($urandom_range(0, 9) == 0)
            push_req(1'($urandom_range(0, 1)), $urandom_range(0, 1023),
                     $urandom_range(0, 1023));
         else
            push_req(1'($urandom_range(0, 1)),
                     $urandom_range(0, (ss + 1 > 1023) ? 1023 : ss + 1),
                     $urandom_range(0, (ls + 1 > 1023) ? 1023 : ls + 1));
      end
   endtask

   task automatic drain();
      while (pending_reqs.size() > 0 || req_tvalid || expected_mesh.size() > 0)
         @(posedge clock);
      repeat (FLUSH_CYCLES) @(posedge clock);
   endtask

   initial begin
      lon_segs_reg = 64;
      lat_segs_reg = 32;
      radius_reg = 25600;
      repeat (9) @(posedge clock);
      reset <= 0;

      set_shape(64, 32, 25600);
      push_req(0, 0, 0);      // north pole
      push_req(0, 32, 0);     // south pole
      push_req(0, 16, 16);
      push_req(0, 16, 48);
      push_req(0, 32, 64);
      push_req(0, 33, 0);     // vertex past last row
      push_req(0, 0, 65);     // vertex past last column
      push_req(0, 1023, 1023);
      push_req(1, 0, 0);      // top row: lower triangle only
      push_req(1, 31, 5);     // bottom row: upper triangle only
      push_req(1, 31, 63);
      push_req(1, 15, 30);
      push_req(1, 32, 0);     // quad out of range
      push_req(1, 0, 64);
      push_req(1, 1023, 1023);
      push_random(90);
      drain();

      // below-minimum counts are raised, zero radius
      set_shape(0, 0, 0);
      push_req(0, 2, 3);
      push_req(1, 1, 2);
      push_random(60);
      drain();

      // maximum counts: corner indices reach the top of the 20-bit range, full radius saturates
      set_shape(1023, 1023, 65535);
      push_req(1, 1022, 1022);
      push_req(0, 1023, 1023);
      push_req(0, 0, 0);
      push_req(0, 512, 256);
      push_random(70);
      drain();

      set_shape(3, 2, $urandom_range(0, 65535));
      push_random(50);
      drain();

      calm = 1;
      set_shape($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 65535));
      push_random(100);
      drain();

      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule

[uv_sphere_tessellator.f]
rtl/uvs_pkg.sv
rtl/uvs_div_cell.sv
rtl/uvs_cordic_cell.sv
rtl/uv_sphere_tessellator.sv
tb/testbench.sv
